/* rtl/rolling_key_byte_descrambler_unit_defines.svh */
// Assertion macros used by the descrambler's back end.
// Define ASSERT_OFF to compile every check away.
`ifndef ROLLING_KEY_BYTE_DESCRAMBLER_UNIT_DEFINES_SVH
`define ROLLING_KEY_BYTE_DESCRAMBLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define RKBD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RKBD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RKBD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RKBD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/rkbd_pkg.sv */
package rkbd_pkg;

	localparam int unsigned KEY_W           = 32;
	localparam int unsigned BYTE_W          = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	typedef enum logic {
		OP_CONT,
		OP_RESTART
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] data;
		logic [KEY_W-1:0]  seed;
	} item_t;

endpackage

/* rtl/rkbd_front.sv */
module rkbd_front import rkbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              start_req,
	input  logic [KEY_W-1:0]  seed,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// A start byte becomes a restart, which reloads the key in the back end.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.op   <= start_req ? OP_RESTART : OP_CONT;
			item_s1.data <= data_byte;
			item_s1.seed <= seed;
		end
	end

endmodule

/* rtl/rkbd_queue.sv */
module rkbd_queue import rkbd_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output item_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t          mem_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= ptr_next(wr_q);
			end
			if (do_pop) begin
				rd_q <= ptr_next(rd_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/rkbd_back.sv */
`include "rolling_key_byte_descrambler_unit_defines.svh"

module rkbd_back import rkbd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] plain_byte
);

	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    cnt_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   plain_byte_q;
	logic [KEY_W-1:0]    key_cur;
	logic [KEY_W-1:0]    cnt_cur;
	logic [2:0]          shamt;
	logic [2*BYTE_W-1:0] word;
	logic [2*BYTE_W-1:0] shifted;
	logic                restart_pop;

	assign pop         = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;
	assign plain_byte  = plain_byte_q;
	assign restart_pop = pop && (head.op == OP_RESTART);

	always_comb begin
		unique case (head.op)
			OP_RESTART: begin
				key_cur = head.seed;
				cnt_cur = '0;
			end
			OP_CONT: begin
				key_cur = key_q;
				cnt_cur = cnt_q;
			end
			default: begin
				key_cur = key_q;
				cnt_cur = cnt_q;
			end
		endcase
	end

	// The shift uses the key after the first update, whose low bits are
	// those of key + count + 1; only three bits of that sum matter.
	assign shamt   = key_cur[2:0] + cnt_cur[2:0] + 3'd1;
	assign word    = {key_cur[BYTE_W-1:0], key_cur[BYTE_W-1:0]};
	assign shifted = word >> shamt;

	// Both updates of one byte fold into key + 2*count + 3 and count + 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				key_q       <= key_cur + {cnt_cur[KEY_W-2:0], 1'b0} + KEY_W'(3);
				cnt_q       <= cnt_cur + KEY_W'(2);
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			plain_byte_q <= head.data ^ shifted[BYTE_W-1:0];
		end
	end

	`RKBD_ASSERT(a_cnt_even, clk, arst_n, cnt_q[0] == 1'b0, "step count became odd")
	`RKBD_ASSERT(a_restart_cnt, clk, arst_n, restart_pop |=> cnt_q == KEY_W'(2), "bad restart count")
	`RKBD_ASSERT(a_pop_shows, clk, arst_n, pop |=> out_valid_q, "item taken with no result")
	`RKBD_ASSERT(a_no_pop_on_stall, clk, arst_n, (out_valid_q && out_stall) |-> !pop, "pop on stall")

endmodule

/* rtl/rolling_key_byte_descrambler_unit.sv */
// Channel   Handshake              Item fields
// input     in_valid / in_stall    data_byte[7:0], start_req, seed[31:0]
// output    out_valid / out_stall  plain_byte[7:0]
//
// One item is taken and one result given per cycle when neither side stalls.
// An item passes the input register, the queue and the result register, in that order,
// before out_valid shows its result.
// The folded key update (key + 2*count + 3) in the back end sets that rate.
// Reset clears the key, the step count and every valid flag.
// While the output stalls, the queue and the input register absorb up to QUEUE_DEPTH + 1
// items before in_stall rises.
module rolling_key_byte_descrambler_unit import rkbd_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              start_req,
	input  logic [KEY_W-1:0]  seed,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] plain_byte
);

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t head;

	rkbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.start_req (start_req),
		.seed      (seed),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rkbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	rkbd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plain_byte (plain_byte)
	);

endmodule
